/* rtl/core/sid_pkg.sv */
`timescale 1ns / 1ps

package sid_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int CHAR_BITS          = 8;
  localparam int DIGIT_BITS         = 4;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture input, take magnitude, clear BCD
    logic dabble;  // one double-dabble step
    logic skip;    // drop a leading zero digit
    logic emit;    // load the next character into the output register
  } sid_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bits_done;     // current dabble step is the final one
    logic top_zero;      // leading BCD digit is zero
    logic one_digit;     // one digit left to send
    logic sign_pending;  // minus sign not yet sent
    logic out_free;      // output register can take a character this cycle
  } sid_stat_t;

endpackage

/* rtl/core/sid_in_if.sv */
`timescale 1ns / 1ps

interface sid_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/core/sid_out_if.sv */
`timescale 1ns / 1ps

interface sid_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/core/sid_ctrl.sv */
`timescale 1ns / 1ps

module sid_ctrl
  import sid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sid_stat_t stat,
  output sid_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (stat.bits_done) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.one_digit) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.sign_pending && stat.one_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/sid_dp.sv */
`timescale 1ns / 1ps

module sid_dp
  import sid_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] in_value,
  input  sid_cmd_t              cmd,
  output sid_stat_t             stat,
  sid_out_if.source             out_ch
);

  // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
  localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS   = NUM_DIGITS * DIGIT_BITS;
  localparam int BCNT_BITS  = $clog2(VALUE_BITS);
  localparam int DCNT_BITS  = $clog2(NUM_DIGITS + 1);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [BCNT_BITS-1:0]  bcnt;
  logic [DCNT_BITS-1:0]  dcnt;
  logic                  sign_pending;
  logic                  out_valid;
  logic [CHAR_BITS-1:0]  out_char;
  logic                  out_last;
  logic [DIGIT_BITS-1:0] top_digit;

  assign top_digit = bcd[BCD_BITS-1 -: DIGIT_BITS];

  // Add 3 to every digit of 5 or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
          bcd[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  assign stat.bits_done    = (bcnt == BCNT_BITS'(VALUE_BITS - 1));
  assign stat.top_zero     = (top_digit == '0);
  assign stat.one_digit    = (dcnt == DCNT_BITS'(1));
  assign stat.sign_pending = sign_pending;
  assign stat.out_free     = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_pending <= 1'b0;
      bcnt         <= '0;
      dcnt         <= '0;
    end else begin
      if (cmd.load) begin
        sign_pending <= in_value[VALUE_BITS-1];
        bcnt         <= '0;
        dcnt         <= DCNT_BITS'(NUM_DIGITS);
      end else if (cmd.dabble) begin
        bcnt <= bcnt + BCNT_BITS'(1);
      end else if (cmd.skip) begin
        dcnt <= dcnt - DCNT_BITS'(1);
      end else if (cmd.emit) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else begin
          dcnt <= dcnt - DCNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
      bcd <= '0;
    end else if (cmd.dabble) begin
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_BITS-2:0], mag[VALUE_BITS-1]};
    end else if (cmd.skip || (cmd.emit && !sign_pending)) begin
      bcd <= {bcd[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (sign_pending) begin
        out_char <= ASCII_MINUS;
        out_last <= 1'b0;
      end else begin
        out_char <= ASCII_ZERO + CHAR_BITS'(top_digit);
        out_last <= (dcnt == DCNT_BITS'(1));
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.character = out_char;
  assign out_ch.last      = out_last;

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text.
// in_ch: one valid/ready transaction carries a two's complement value of
//   VALUE_BITS bits. out_ch: one transaction per character, most significant
//   first; a negative value opens with '-', zero gives a single '0', and
//   last is high on the final character. No terminator is sent.
// Steps: an accepted value is loaded, then takes VALUE_BITS double-dabble
//   steps (one input bit per cycle through the BCD shift register), drops
//   its leading zeros one at a time, then sends its characters. Dropped
//   zeros plus digits always add up to the number of BCD digits. Most of
//   the time goes to the bit-serial conversion loop while the receiver
//   keeps up.
// in_ch.ready is high only while the controller is idle. The final character
//   sits in the output register, so the next value is taken while it waits.
// A stall on out_ch freezes the output register and holds the controller in
//   its emit state; nothing is dropped.
// Reset (rst, synchronous) returns the controller to idle and empties the
//   output register; no other state carries between values.

module signed_int_to_decimal_ascii
  import sid_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)(
  input logic       clk,
  input logic       rst,
  sid_in_if.sink    in_ch,
  sid_out_if.source out_ch
);

  sid_cmd_t  cmd;
  sid_stat_t stat;

  // Controller: idle, convert, leading-zero skip, emit.
  sid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: magnitude, BCD shifter, counters and the output register.
  sid_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .stat     (stat),
    .out_ch   (out_ch)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for the signed integer to decimal ASCII converter.
// A queue of values (a directed group, then random values) feeds a bursty
// driver; every accepted value is expanded into its expected characters,
// which the monitor checks in order against the output channel.

module tb_top;
  import sid_pkg::*;

  localparam int          VB          = 32;
  localparam int          RANDOM_VALS = 380;
  // Worst case per value: the driver's idle gap, the conversion, and 11 chars
  // behind a sparse ready pattern; the limit must cover ~400 such values.
  localparam int unsigned CYCLE_LIMIT = 800_000;
  localparam int          DRAIN_WAIT  = 80;

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
  } text_char_t;

  logic clk;
  logic rst;

  sid_in_if #(.VALUE_BITS(VB)) in_bus ();
  sid_out_if                   out_bus ();

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VB)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Values still to be offered, and characters owed by accepted values.
  logic [VB-1:0] values_to_send[$];
  text_char_t    chars_due[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;

  // Sender burst/gap bookkeeping.
  int unsigned burst_left;
  int unsigned gap_left;

  // Receiver: a 16-bit ready pattern rotated every cycle, reloaded now and then.
  logic [15:0] ready_pattern;
  int unsigned pattern_age;

  always #5 clk = ~clk;

  // Expected text for one value: optional '-', then digits MSB first;
  // the final character carries last.
  task automatic queue_decimal_text(input logic [VB-1:0] value);
    logic [VB-1:0]        magnitude;
    logic [CHAR_BITS-1:0] digits[$];
    text_char_t           tc;
    begin
      magnitude = value;
      if (value[VB-1]) begin
        // unsigned negation: the most negative value maps to 2^(VB-1)
        magnitude = -value;
        tc.character = ASCII_MINUS;
        tc.last      = 1'b0;
        chars_due.push_back(tc);
      end
      do begin
        digits.push_front(ASCII_ZERO + CHAR_BITS'(magnitude % 10));
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      foreach (digits[i]) begin
        tc.character = digits[i];
        tc.last      = (i == digits.size() - 1);
        chars_due.push_back(tc);
      end
    end
  endtask

  function automatic longint ten_pow(input int k);
    longint p;
    begin
      p = 1;
      for (int i = 0; i < k; i++) p = p * 10;
      return p;
    end
  endfunction

  // Random value shaped to cover every text length, decade boundaries,
  // small numbers and the full bit range.
  function automatic logic [VB-1:0] random_value();
    longint        lo;
    longint        hi;
    longint        mag;
    int            ndig;
    logic [VB-1:0] bits;
    begin
      mag = 0;
      case ($urandom_range(0, 5))
        0: begin
          // uniform over a decimal length
          ndig = $urandom_range(1, 10);
          lo   = (ndig == 1) ? 0 : ten_pow(ndig - 1);
          hi   = ten_pow(ndig) - 1;
          if (hi > 64'd2147483647) hi = 64'd2147483647;
          mag  = lo + (longint'($urandom) % (hi - lo + 1));
        end
        1: mag = $urandom_range(0, 20);
        2: begin
          // just around a power of ten
          mag = ten_pow($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
        end
        default: return $urandom;
      endcase
      bits = VB'(mag);
      if ($urandom_range(0, 1) == 1) bits = -bits;
      return bits;
    end
  endfunction

  // Stimulus and end of run.
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_bus.valid   = 1'b0;
    in_bus.value   = '0;
    out_bus.ready  = 1'b0;
    mismatch_count = 0;

    // directed: zero, single digits, decade edges, extremes, bit patterns
    values_to_send.push_back(32'sd0);
    values_to_send.push_back(32'sd1);
    values_to_send.push_back(-32'sd1);
    values_to_send.push_back(32'sd9);
    values_to_send.push_back(-32'sd9);
    values_to_send.push_back(32'sd10);
    values_to_send.push_back(-32'sd10);
    values_to_send.push_back(32'sd99);
    values_to_send.push_back(32'sd100);
    values_to_send.push_back(32'sd999999999);
    values_to_send.push_back(32'sd1000000000);
    values_to_send.push_back(-32'sd999999999);
    values_to_send.push_back(-32'sd1000000000);
    values_to_send.push_back(32'sd1234567890);
    values_to_send.push_back(32'sd2147483646);
    values_to_send.push_back(32'sd2147483647);  // most positive
    values_to_send.push_back(32'h8000_0000);    // most negative
    values_to_send.push_back(32'h8000_0001);
    values_to_send.push_back(32'h5555_5555);
    values_to_send.push_back(32'hAAAA_AAAA);
    values_to_send.push_back(32'h0000_FFFF);
    values_to_send.push_back(32'hFFFF_0000);
    for (int n = 0; n < RANDOM_VALS; n++) values_to_send.push_back(random_value());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // all values accepted, then all characters back, then a quiet tail
    while (values_to_send.size() != 0 || in_bus.valid) @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && chars_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: bursts of 1..8 values, then, three times in four, a random idle
  // gap so that the next value arrives at every phase of a conversion.
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      burst_left   = $urandom_range(1, 8);
      gap_left     = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) queue_decimal_text(in_bus.value);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0 || values_to_send.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.value <= values_to_send.pop_front();
          in_bus.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
          end
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest owed char,
  // and drive ready from the rotating pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      ready_pattern = 16'hFFFF;
      pattern_age   = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (chars_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected char %0d last %0b, nothing owed",
                   $time, out_bus.character, out_bus.last);
        end else if (out_bus.character !== chars_due[0].character ||
                     out_bus.last !== chars_due[0].last) begin
          mismatch_count++;
          $display("%0t: expected char %0d last %0b, got char %0d last %0b",
                   $time, chars_due[0].character, chars_due[0].last,
                   out_bus.character, out_bus.last);
          void'(chars_due.pop_front());
        end else begin
          void'(chars_due.pop_front());
        end
      end
      if (pattern_age == 0) begin
        // always ready, random, mostly ready, or mostly stalled
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'($urandom);
          2:       ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'($urandom & $urandom);
        endcase
        if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
        pattern_age = $urandom_range(20, 120);
      end else begin
        pattern_age--;
      end
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      out_bus.ready <= ready_pattern[0];
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

/* filelist.f */
rtl/core/sid_pkg.sv
rtl/core/sid_in_if.sv
rtl/core/sid_out_if.sv
rtl/core/sid_ctrl.sv
rtl/core/sid_dp.sv
rtl/core/signed_int_to_decimal_ascii.sv
sim/tb_top.sv
